>>> hdl/ids_pkg.sv
// shared types, codes and character constants for the include directive scanner
package ids_pkg;

    // default nesting limit for block comments
    localparam int unsigned MAX_COMMENT_DEPTH_DEF = 255;

    // depth of the queue between scanner and output stage
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // result kinds
    typedef enum logic [1:0] {
        KIND_PATH_BYTE = 2'd0,
        KIND_PATH_END  = 2'd1,
        KIND_DONE      = 2'd2,
        KIND_MALFORMED = 2'd3
    } t_kind;

    // input item
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in;

    // result item
    typedef struct packed {
        t_kind      kind;
        logic [7:0] path_byte;
    } t_out;

    // queue entry: one or two results caused by one input item
    typedef struct packed {
        logic two;
        t_out r0;
        t_out r1;
    } t_entry;

    // push side of the queue
    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

    // characters the scanner reacts to
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    // keyword letters, "include"
    localparam int unsigned KW_LEN = 7;
    localparam logic [7:0] KEYWORD [KW_LEN] = '{8'h69, 8'h6E, 8'h63, 8'h6C, 8'h75, 8'h64, 8'h65};
    localparam logic [3:0] KW_MATCHED  = 4'd7;
    localparam logic [3:0] KW_MISMATCH = 4'd8;

endpackage

>>> hdl/ids_front.sv
// byte scanner: accepts text items, tracks scan state and queues the results
module ids_front #(
    parameter int unsigned MAX_COMMENT_DEPTH = ids_pkg::MAX_COMMENT_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ids_pkg::t_in  i_item,
    input  logic          i_space,
    output ids_pkg::t_push o_push
);
    import ids_pkg::*;

    localparam int unsigned DEPTH_W = $clog2(MAX_COMMENT_DEPTH + 1);

    // scan modes
    typedef enum logic [8:0] {
        M_TOP       = 9'b000000001,
        M_TOP_LINE  = 9'b000000010,
        M_TOP_BLOCK = 9'b000000100,
        M_STR       = 9'b000001000,
        M_WORD      = 9'b000010000,
        M_INC       = 9'b000100000,
        M_INC_LINE  = 9'b001000000,
        M_INC_BLOCK = 9'b010000000,
        M_PATH      = 9'b100000000
    } t_mode;

    // half of a two-byte comment marker
    typedef enum logic [1:0] {
        P_NONE  = 2'd0,
        P_SLASH = 2'd1,
        P_STAR  = 2'd2
    } t_pend;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_USCORE);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

    t_mode               r_mode, n_mode;
    t_pend               r_pend, n_pend;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [3:0]          r_kw, n_kw;
    logic                r_quote, n_quote;
    logic                r_nonempty, n_nonempty;
    logic                r_err, n_err;

    logic       accept;
    logic [7:0] b;
    logic [7:0] delim;
    t_mode      eff;
    t_mode      blk_back;
    logic       done;
    logic       bad;
    logic       has0, two;
    t_out       res0, res1, verdict;

    assign accept  = i_valid && i_space;
    assign o_ready = i_space;
    assign b       = i_item.text_byte;
    assign delim   = r_quote ? CH_SQUOTE : CH_DQUOTE;

    // next scan state and results for the byte on the input
    always_comb begin
        n_mode     = r_mode;
        n_pend     = r_pend;
        n_depth    = r_depth;
        n_kw       = r_kw;
        n_quote    = r_quote;
        n_nonempty = r_nonempty;
        n_err      = r_err;
        eff        = r_mode;
        blk_back   = M_TOP;
        done       = 1'b0;
        bad        = 1'b0;
        has0       = 1'b0;
        two        = 1'b0;
        res0       = '0;
        res1       = '0;
        verdict    = '0;

        if (!r_err) begin
            // a word ends: go on as keyword tail or as top level
            if (r_mode == M_WORD && !is_ident(b)) begin
                n_kw   = '0;
                eff    = (r_kw == KW_MATCHED) ? M_INC : M_TOP;
                n_mode = eff;
            end
            blk_back = (eff == M_TOP_BLOCK) ? M_TOP : M_INC;

            unique case (eff)
                M_TOP: begin
                    if (r_pend == P_SLASH) begin
                        n_pend = P_NONE;
                        if (b == CH_SLASH) begin
                            n_mode = M_TOP_LINE;
                            done   = 1'b1;
                        end else if (b == CH_STAR) begin
                            n_depth = DEPTH_W'(1);
                            n_mode  = M_TOP_BLOCK;
                            done    = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (is_space(b)) begin
                            n_mode = n_mode;
                        end else if (b == CH_SLASH) begin
                            n_pend = P_SLASH;
                        end else if (is_quote(b)) begin
                            n_quote = (b == CH_SQUOTE);
                            n_mode  = M_STR;
                        end else if (is_alpha(b) || b == CH_USCORE) begin
                            n_kw   = (b == KEYWORD[0]) ? 4'd1 : KW_MISMATCH;
                            n_mode = M_WORD;
                        end
                    end
                end
                M_TOP_LINE: begin
                    if (b == CH_CR || b == CH_LF) begin
                        n_mode = M_TOP;
                    end
                end
                M_INC_LINE: begin
                    if (b == CH_CR || b == CH_LF) begin
                        n_mode = M_INC;
                    end
                end
                M_TOP_BLOCK, M_INC_BLOCK: begin
                    if (r_pend == P_SLASH) begin
                        n_pend = P_NONE;
                        if (b == CH_STAR) begin
                            if (r_depth >= DEPTH_W'(MAX_COMMENT_DEPTH)) begin
                                n_err = 1'b1;
                            end else begin
                                n_depth = r_depth + DEPTH_W'(1);
                            end
                            done = 1'b1;
                        end
                    end else if (r_pend == P_STAR) begin
                        n_pend = P_NONE;
                        if (b == CH_SLASH) begin
                            n_depth = r_depth - DEPTH_W'(1);
                            if (r_depth == DEPTH_W'(1)) begin
                                n_mode = blk_back;
                            end
                            done = 1'b1;
                        end
                    end
                    if (!done) begin
                        if (b == CH_SLASH) begin
                            n_pend = P_SLASH;
                        end else if (b == CH_STAR) begin
                            n_pend = P_STAR;
                        end
                    end
                end
                M_STR: begin
                    if (b == delim) begin
                        n_mode = M_TOP;
                    end
                end
                M_WORD: begin
                    // only identifier bytes reach here
                    if (r_kw < 4'(KW_LEN) && b == KEYWORD[r_kw[2:0]]) begin
                        n_kw = r_kw + 4'd1;
                    end else begin
                        n_kw = KW_MISMATCH;
                    end
                end
                M_INC: begin
                    if (r_pend == P_SLASH) begin
                        n_pend = P_NONE;
                        if (b == CH_SLASH) begin
                            n_mode = M_INC_LINE;
                        end else if (b == CH_STAR) begin
                            n_depth = DEPTH_W'(1);
                            n_mode  = M_INC_BLOCK;
                        end else begin
                            n_err = 1'b1;
                        end
                    end else if (is_space(b)) begin
                        n_mode = n_mode;
                    end else if (b == CH_SLASH) begin
                        n_pend = P_SLASH;
                    end else if (is_quote(b)) begin
                        n_quote    = (b == CH_SQUOTE);
                        n_nonempty = 1'b0;
                        n_mode     = M_PATH;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                M_PATH: begin
                    if (b == delim) begin
                        if (!r_nonempty) begin
                            n_err = 1'b1;
                        end else begin
                            has0       = 1'b1;
                            res0.kind  = KIND_PATH_END;
                            n_nonempty = 1'b0;
                            n_mode     = M_TOP;
                        end
                    end else if (b == CH_CR || b == CH_LF) begin
                        n_err = 1'b1;
                    end else begin
                        has0           = 1'b1;
                        res0.kind      = KIND_PATH_BYTE;
                        res0.path_byte = b;
                        n_nonempty     = 1'b1;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end

        // verdict on the final byte, then back to the reset state
        if (i_item.last_byte) begin
            bad = n_err;
            if (!bad) begin
                if (n_mode == M_WORD) begin
                    bad = (n_kw == KW_MATCHED);
                end else if (n_mode != M_TOP && n_mode != M_TOP_LINE && n_mode != M_STR) begin
                    bad = 1'b1;
                end
            end
            verdict.kind = bad ? KIND_MALFORMED : KIND_DONE;
            if (has0) begin
                res1 = verdict;
                two  = 1'b1;
            end else begin
                res0 = verdict;
                has0 = 1'b1;
            end
            n_mode     = M_TOP;
            n_pend     = P_NONE;
            n_depth    = '0;
            n_kw       = '0;
            n_quote    = 1'b0;
            n_nonempty = 1'b0;
            n_err      = 1'b0;
        end
    end

    // queue push for items that cause results
    always_comb begin
        o_push.push     = accept && has0;
        o_push.entry.two = two;
        o_push.entry.r0  = res0;
        o_push.entry.r1  = res1;
    end

    // scan state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_TOP;
            r_pend     <= P_NONE;
            r_depth    <= '0;
            r_kw       <= '0;
            r_quote    <= 1'b0;
            r_nonempty <= 1'b0;
            r_err      <= 1'b0;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_pend     <= n_pend;
            r_depth    <= n_depth;
            r_kw       <= n_kw;
            r_quote    <= n_quote;
            r_nonempty <= n_nonempty;
            r_err      <= n_err;
        end
    end

endmodule

>>> hdl/ids_fifo.sv
// short queue of result entries between scanner and output stage
module ids_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ids_pkg::t_push  i_push,
    output logic            o_space,
    input  logic            i_pop,
    output ids_pkg::t_entry o_head,
    output logic            o_empty
);
    import ids_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;
    logic                do_pop;

    assign o_space = (r_cnt != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (i_push.push && !do_pop) begin
                r_cnt <= r_cnt + (QUEUE_AW + 1)'(1);
            end else if (!i_push.push && do_pop) begin
                r_cnt <= r_cnt - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

>>> hdl/ids_back.sv
// output stage: takes queue entries apart into single result items
module ids_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ids_pkg::t_entry i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output ids_pkg::t_out   o_item
);
    import ids_pkg::*;

    logic r_valid;
    logic r_sel;
    t_out r_item;
    logic load;

    assign load    = !r_valid || i_ready;
    assign o_pop   = load && !i_empty && (r_sel || !i_head.two);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_sel <= !r_sel && i_head.two;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_item <= r_sel ? i_head.r1 : i_head.r0;
        end
    end

endmodule

>>> hdl/include_directive_scanner.sv
// top level: include directive scanner, one text byte per item
// path: a byte's results pass through the result queue, then the output register
// throughput: one byte per cycle while the queue has space; a byte with two results
// sends them in turn, and the four-entry result queue absorbs those pairs and output stalls
// reset: synchronous active-low, returns the scanner to top level scanning with no pending state
// no clearing pass: the block takes items in the first cycle after reset
module include_directive_scanner #(
    parameter int unsigned MAX_COMMENT_DEPTH = ids_pkg::MAX_COMMENT_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ids_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ids_pkg::t_out o_out_item
);
    import ids_pkg::*;

    t_push  push;
    t_entry head;
    logic   space;
    logic   empty;
    logic   pop;

    // scanner front
    ids_front #(
        .MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_space (space),
        .o_push  (push)
    );

    // result queue
    ids_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    // output stage
    ids_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule
